// ===== hw/rtl/tnc_pkg.sv =====
// Shared types, constants and helper functions of the toroidal neighbour count block.
package tnc_pkg;

  localparam int unsigned CoordW = 7;
  localparam int unsigned CellW  = 2 * CoordW;
  localparam int unsigned CntW   = 6;
  localparam int unsigned StrW   = 2;
  localparam int unsigned RadW   = 2;
  localparam int unsigned CfgW   = 6;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [CellW-1:0]  cell_t;
  typedef logic [CntW-1:0]   cnt6_t;
  typedef logic [StrW-1:0]   strain_t;
  typedef logic [RadW-1:0]   rad_t;

  typedef struct packed {
    cnt6_t sig;
    logic  prod;
    cnt6_t good;
  } cnt_t;

  localparam logic [1:0] ReqRestart = 2'd0;
  localparam logic [1:0] ReqSet     = 2'd1;

  localparam logic [1:0] CfgSigRad   = 2'd0;
  localparam logic [1:0] CfgGoodRad  = 2'd1;
  localparam logic [1:0] CfgProdThr  = 2'd2;
  localparam logic [1:0] CfgGoodThr  = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_B_RD,
    ST_B_CHK,
    ST_C_RD,
    ST_C_WR,
    ST_D_RD,
    ST_D_CHK,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_W_RD,
    ST_W_WR,
    ST_G_RD,
    ST_G_WR,
    ST_RESP_RD,
    ST_RESP
  } st_e;

  function automatic logic recv_bit(strain_t s);
    return s[1];
  endfunction

  function automatic logic sig_bit(strain_t s);
    return s[0];
  endfunction

  function automatic cnt6_t win_area(rad_t rad);
    cnt6_t a;
    unique case (rad)
      2'd0: a = 6'd1;
      2'd1: a = 6'd9;
      2'd2: a = 6'd25;
      default: a = 6'd49;
    endcase
    return a;
  endfunction

  function automatic cnt6_t own_level(cnt6_t ones, strain_t s, rad_t rad);
    return recv_bit(s) ? ones : cnt6_t'(win_area(rad) - ones);
  endfunction

endpackage

// ===== hw/rtl/toroidal_neighbour_count_update_top.sv =====
// Top level: request sequencer, state memories and result register of the grid count keeper.
// The block keeps a 128 x 128 torus of 2-bit strains with, for every cell, its window
// signal count, producer flag and public-good count, held in two memories with registered
// read data that a sequencer reads, modifies and writes back one entry at a time. A set
// request writes the new strain, updates the signal window of the cell and, for every
// cell whose producer flag flips, the good window of that cell. A restart, every
// configuration write and the end of reset rebuild all counts: one clearing pass over the
// 16384 cells, one strain scan that adds each signal-1 cell over its window, one pass that
// sets the producer flags and one that spreads each producer over its good window. No
// request is taken while a rebuild runs. A finished result waits in an output register
// while the next request is taken.
module toroidal_neighbour_count_update_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  tnc_pkg::coord_t             row_i,
  input  tnc_pkg::coord_t             col_i,
  input  tnc_pkg::strain_t            new_strain_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tnc_pkg::strain_t            cell_strain_o,
  output tnc_pkg::cnt6_t              own_signal_level_o,
  output logic                        is_producer_o,
  output tnc_pkg::cnt6_t              good_level_o,
  output logic                        enjoys_good_o,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [tnc_pkg::CfgW-1:0]    cfg_data_i
);
  import tnc_pkg::*;

  st_e     state_q, state_d;
  rad_t    sig_rad_q, good_rad_q;
  cnt6_t   prod_need_q, good_thr_q;
  cell_t   scan_q, scan_d;
  logic    clr_str_q, clr_str_d;
  logic    set_mode_q, set_mode_d;
  logic    resp_pend_q, resp_pend_d;
  logic    sig_chg_q, sig_chg_d, sig_up_q, sig_up_d, gup_q, gup_d;
  logic    out_valid_q, out_valid_d;
  coord_t  row_q, col_q;
  strain_t new_strain_q;
  strain_t res_strain_q;
  cnt6_t   res_own_q, res_good_q;
  logic    res_prod_q, res_enjoy_q;

  logic    accept, scan_last;
  cell_t   p_addr, sw_addr, gw_addr;
  coord_t  sw_row, sw_col, gw_row, gw_col;
  logic    sw_last, gw_last;
  logic    sw_start, sw_step, gw_start, gw_step;
  coord_t  sw_ctr_row, sw_ctr_col, gw_ctr_row, gw_ctr_col;

  logic    str_we, cnt_we;
  cell_t   str_waddr, str_raddr, cnt_waddr, cnt_raddr;
  strain_t str_wdata, str_rd;
  cnt_t    cnt_wdata, cnt_rd;
  logic [$bits(cnt_t)-1:0] cnt_rdata;

  cnt6_t   w_sig;
  logic    w_prod, go_g, c_prod, out_load;

  assign accept    = (state_q == ST_IDLE) && in_valid_i && !cfg_we_i;
  assign in_stall_o = (state_q != ST_IDLE) || cfg_we_i;
  assign scan_last = &scan_q;
  assign p_addr    = {row_q, col_q};
  assign sw_addr   = {sw_row, sw_col};
  assign gw_addr   = {gw_row, gw_col};
  assign cnt_rd    = cnt_t'(cnt_rdata);

  always_comb begin
    w_sig = cnt_rd.sig;
    if (sig_chg_q) begin
      w_sig = sig_up_q ? cnt6_t'(cnt_rd.sig + 6'd1) : cnt6_t'(cnt_rd.sig - 6'd1);
    end
  end
  assign w_prod = set_mode_q ? (own_level(w_sig, str_rd, sig_rad_q) >= prod_need_q)
                             : cnt_rd.prod;
  assign go_g   = set_mode_q && (w_prod != cnt_rd.prod);
  assign c_prod = own_level(cnt_rd.sig, str_rd, sig_rad_q) >= prod_need_q;
  assign out_load = (state_q == ST_RESP) && (!out_valid_q || !out_stall_i);

  tnc_ram #(.Width(StrW), .AddrW(CellW)) u_str_ram (
    .clk_i   (clk_i),
    .we_i    (str_we),
    .waddr_i (str_waddr),
    .wdata_i (str_wdata),
    .raddr_i (str_raddr),
    .rdata_o (str_rd)
  );

  tnc_ram #(.Width($bits(cnt_t)), .AddrW(CellW)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  tnc_win u_sig_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sw_start),
    .step_i    (sw_step),
    .ctr_row_i (sw_ctr_row),
    .ctr_col_i (sw_ctr_col),
    .rad_i     (sig_rad_q),
    .row_o     (sw_row),
    .col_o     (sw_col),
    .last_o    (sw_last)
  );

  tnc_win u_good_win (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (gw_start),
    .step_i    (gw_step),
    .ctr_row_i (gw_ctr_row),
    .ctr_col_i (gw_ctr_col),
    .rad_i     (good_rad_q),
    .row_o     (gw_row),
    .col_o     (gw_col),
    .last_o    (gw_last)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (scan_last) state_d = ST_B_RD;
      end
      ST_B_RD:  state_d = ST_B_CHK;
      ST_B_CHK: begin
        if (sig_bit(str_rd)) state_d = ST_W_RD;
        else state_d = scan_last ? ST_C_RD : ST_B_RD;
      end
      ST_W_RD:  state_d = ST_W_WR;
      ST_W_WR: begin
        if (go_g) state_d = ST_G_RD;
        else if (!sw_last) state_d = ST_W_RD;
        else if (set_mode_q) state_d = ST_RESP_RD;
        else state_d = scan_last ? ST_C_RD : ST_B_RD;
      end
      ST_G_RD:  state_d = ST_G_WR;
      ST_G_WR: begin
        if (!gw_last) state_d = ST_G_RD;
        else if (set_mode_q) state_d = sw_last ? ST_RESP_RD : ST_W_RD;
        else if (!scan_last) state_d = ST_D_RD;
        else state_d = resp_pend_q ? ST_RESP_RD : ST_IDLE;
      end
      ST_C_RD:  state_d = ST_C_WR;
      ST_C_WR:  state_d = scan_last ? ST_D_RD : ST_C_RD;
      ST_D_RD:  state_d = ST_D_CHK;
      ST_D_CHK: begin
        if (cnt_rd.prod) state_d = ST_G_RD;
        else if (!scan_last) state_d = ST_D_RD;
        else state_d = resp_pend_q ? ST_RESP_RD : ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            ReqRestart: state_d = ST_CLEAR;
            ReqSet:     state_d = ST_SET_RD;
            default:    state_d = ST_RESP_RD;
          endcase
        end
      end
      ST_SET_RD:  state_d = ST_SET_WR;
      ST_SET_WR:  state_d = ST_W_RD;
      ST_RESP_RD: state_d = ST_RESP;
      ST_RESP: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (cfg_we_i) state_d = ST_CLEAR;
  end

  always_comb begin
    scan_d      = scan_q;
    clr_str_d   = clr_str_q;
    set_mode_d  = set_mode_q;
    resp_pend_d = resp_pend_q;
    sig_chg_d   = sig_chg_q;
    sig_up_d    = sig_up_q;
    gup_d       = gup_q;
    out_valid_d = out_valid_q && out_stall_i;
    str_we      = 1'b0;
    str_waddr   = scan_q;
    str_wdata   = '0;
    str_raddr   = p_addr;
    cnt_we      = 1'b0;
    cnt_waddr   = scan_q;
    cnt_wdata   = '0;
    cnt_raddr   = p_addr;
    sw_start    = 1'b0;
    sw_step     = 1'b0;
    sw_ctr_row  = scan_q[CellW-1:CoordW];
    sw_ctr_col  = scan_q[CoordW-1:0];
    gw_start    = 1'b0;
    gw_step     = 1'b0;
    gw_ctr_row  = scan_q[CellW-1:CoordW];
    gw_ctr_col  = scan_q[CoordW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        cnt_we = 1'b1;
        str_we = clr_str_q;
        scan_d = scan_q + 1'b1;
        if (scan_last) clr_str_d = 1'b0;
      end
      ST_B_RD: str_raddr = scan_q;
      ST_B_CHK: begin
        if (sig_bit(str_rd)) begin
          sw_start  = 1'b1;
          sig_chg_d = 1'b1;
          sig_up_d  = 1'b1;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_W_RD: begin
        str_raddr = sw_addr;
        cnt_raddr = sw_addr;
      end
      ST_W_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = sw_addr;
        cnt_wdata = '{sig: w_sig, prod: w_prod, good: cnt_rd.good};
        if (go_g) begin
          gw_start   = 1'b1;
          gw_ctr_row = sw_row;
          gw_ctr_col = sw_col;
          gup_d      = w_prod;
        end else if (!sw_last) begin
          sw_step = 1'b1;
        end else if (!set_mode_q) begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_G_RD: cnt_raddr = gw_addr;
      ST_G_WR: begin
        cnt_we    = 1'b1;
        cnt_waddr = gw_addr;
        cnt_wdata = cnt_rd;
        cnt_wdata.good = gup_q ? cnt6_t'(cnt_rd.good + 6'd1) : cnt6_t'(cnt_rd.good - 6'd1);
        if (!gw_last) begin
          gw_step = 1'b1;
        end else if (set_mode_q) begin
          sw_step = !sw_last;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_C_RD: begin
        str_raddr = scan_q;
        cnt_raddr = scan_q;
      end
      ST_C_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = '{sig: cnt_rd.sig, prod: c_prod, good: cnt_rd.good};
        scan_d    = scan_q + 1'b1;
      end
      ST_D_RD: cnt_raddr = scan_q;
      ST_D_CHK: begin
        if (cnt_rd.prod) begin
          gw_start = 1'b1;
          gup_d    = 1'b1;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          resp_pend_d = 1'b1;
          set_mode_d  = 1'b0;
          if (req_type_i == ReqRestart) begin
            clr_str_d = 1'b1;
            scan_d    = '0;
          end
        end
      end
      ST_SET_RD: str_raddr = p_addr;
      ST_SET_WR: begin
        str_we     = 1'b1;
        str_waddr  = p_addr;
        str_wdata  = new_strain_q;
        sig_chg_d  = sig_bit(str_rd) != sig_bit(new_strain_q);
        sig_up_d   = sig_bit(new_strain_q);
        set_mode_d = 1'b1;
        sw_start   = 1'b1;
        sw_ctr_row = row_q;
        sw_ctr_col = col_q;
      end
      ST_RESP_RD: begin
        str_raddr = p_addr;
        cnt_raddr = p_addr;
      end
      ST_RESP: begin
        str_raddr = p_addr;
        cnt_raddr = p_addr;
        if (out_load) begin
          out_valid_d = 1'b1;
          resp_pend_d = 1'b0;
        end
      end
      default: ;
    endcase
    if (cfg_we_i) begin
      scan_d     = '0;
      set_mode_d = 1'b0;
      clr_str_d  = (state_q == ST_CLEAR) ? clr_str_q : 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      scan_q      <= '0;
      clr_str_q   <= 1'b1;
      set_mode_q  <= 1'b0;
      resp_pend_q <= 1'b0;
      sig_chg_q   <= 1'b0;
      sig_up_q    <= 1'b0;
      gup_q       <= 1'b0;
      out_valid_q <= 1'b0;
      sig_rad_q   <= 2'd1;
      good_rad_q  <= 2'd1;
      prod_need_q <= 6'd6;
      good_thr_q  <= 6'd6;
    end else begin
      state_q     <= state_d;
      scan_q      <= scan_d;
      clr_str_q   <= clr_str_d;
      set_mode_q  <= set_mode_d;
      resp_pend_q <= resp_pend_d;
      sig_chg_q   <= sig_chg_d;
      sig_up_q    <= sig_up_d;
      gup_q       <= gup_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgSigRad:  sig_rad_q   <= cfg_data_i[RadW-1:0];
          CfgGoodRad: good_rad_q  <= cfg_data_i[RadW-1:0];
          CfgProdThr: prod_need_q <= cfg_data_i;
          CfgGoodThr: good_thr_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q        <= row_i;
      col_q        <= col_i;
      new_strain_q <= new_strain_i;
    end
    if (out_load) begin
      res_strain_q <= str_rd;
      res_own_q    <= own_level(cnt_rd.sig, str_rd, sig_rad_q);
      res_prod_q   <= cnt_rd.prod;
      res_good_q   <= cnt_rd.good;
      res_enjoy_q  <= cnt_rd.good >= good_thr_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign cell_strain_o      = res_strain_q;
  assign own_signal_level_o = res_own_q;
  assign is_producer_o      = res_prod_q;
  assign good_level_o       = res_good_q;
  assign enjoys_good_o      = res_enjoy_q;

endmodule

// ===== hw/rtl/tnc_ram.sv =====
// Simple dual-port synchronous memory with registered read data.
module tnc_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned AddrW = 14
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [2**AddrW];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/tnc_win.sv =====
// Address walker over the square toroidal window around a center cell.
module tnc_win (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           step_i,
  input  tnc_pkg::coord_t ctr_row_i,
  input  tnc_pkg::coord_t ctr_col_i,
  input  tnc_pkg::rad_t   rad_i,
  output tnc_pkg::coord_t row_o,
  output tnc_pkg::coord_t col_o,
  output logic           last_o
);
  import tnc_pkg::*;

  coord_t     ctr_row_q, ctr_col_q;
  rad_t       rad_q;
  logic [2:0] a_q, b_q, span;

  assign span   = {rad_q, 1'b0};
  assign row_o  = coord_t'(ctr_row_q - coord_t'(rad_q) + coord_t'(a_q));
  assign col_o  = coord_t'(ctr_col_q - coord_t'(rad_q) + coord_t'(b_q));
  assign last_o = (a_q == span) && (b_q == span);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ctr_row_q <= ctr_row_i;
      ctr_col_q <= ctr_col_i;
      rad_q     <= rad_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
    end else if (start_i) begin
      a_q <= '0;
      b_q <= '0;
    end else if (step_i) begin
      if (b_q == span) begin
        b_q <= '0;
        a_q <= a_q + 3'd1;
      end else begin
        b_q <= b_q + 3'd1;
      end
    end
  end

endmodule
